// ===== sv/topological_sort_kahn_assert.svh =====
// Assertion macros shared by the sort engine RTL
`ifndef TOPOLOGICAL_SORT_KAHN_ASSERT_SVH
`define TOPOLOGICAL_SORT_KAHN_ASSERT_SVH

// Check that a condition holds on every clock out of reset
`define TSK_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define TSK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== sv/tsk_pkg.sv =====
// ----------------------------------------------------------------------------
// tsk_pkg
// Item types and fixed field widths for the topological sort engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tsk_pkg;

  localparam int NODE_W = 6;
  localparam int CFG_W  = 7;

  // Command codes
  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_RUN = 1'b1;

  typedef struct packed {
    logic              func;
    logic [NODE_W-1:0] src_node;
    logic [NODE_W-1:0] dst_node;
  } cmd_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_out;
    logic              last;
    logic              cycle_found;
    logic              edges_dropped;
  } res_item_t;

endpackage

`default_nettype wire

// ===== sv/tsk_ram.sv =====
// ----------------------------------------------------------------------------
// tsk_ram
// Simple dual-port memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsk_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 2,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write, then read with old data on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/topological_sort_kahn.sv =====
// Edge load: one command item per cycle while idle; the edge lands in the edge
//   memory and its in-degree update completes in the cycle after.
// Run: the edge memory is scanned in full for every popped node.
// Reset: a clearing pass over all MAX_NODES entries zeroes the in-degree memory;
//   commands are held off until it ends. node_count resets to 1.
// ----------------------------------------------------------------------------
// topological_sort_kahn
// Kahn sort engine built around an edge memory, an in-degree memory with
// read-modify-write forwarding, and a ready-queue memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module topological_sort_kahn #(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 1024
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [tsk_pkg::CFG_W-1:0] cfg_data,
  input  wire logic                    cmd_valid,
  output logic                         cmd_ready,
  input  wire tsk_pkg::cmd_item_t      cmd,
  output logic                         res_valid,
  input  wire logic                    res_ready,
  output tsk_pkg::res_item_t           res
);

  localparam int NAW = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int DW  = ECW;
  localparam int NW  = tsk_pkg::NODE_W;
  localparam int CW  = tsk_pkg::CFG_W;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_ADJ   = 9'b000000100,
    S_SEED  = 9'b000001000,
    S_POPRD = 9'b000010000,
    S_POPWT = 9'b000100000,
    S_SCAN  = 9'b001000000,
    S_EMRD  = 9'b010000000,
    S_EMLD  = 9'b100000000
  } state_t;

  state_t         state;
  logic [NCW-1:0] n_reg;
  logic [ECW-1:0] total;
  logic           drop;
  logic [NCW-1:0] head;
  logic [NCW-1:0] tail;
  logic [NCW-1:0] cnt;
  logic [ECW-1:0] e_cnt;
  logic [NW-1:0]  node;
  logic           cyc;
  logic           p1_v;
  logic           p2_v;
  logic           p2_inc;
  logic           p2_push;
  logic [NAW-1:0] p2_d;
  logic           sd_v;
  logic [NAW-1:0] sd_i;
  logic           fw_v;
  logic [NAW-1:0] fw_a;
  logic [DW-1:0]  fw_d;

  // Memory ports
  logic             e_we;
  logic [EAW-1:0]   e_waddr;
  logic [2*NW-1:0]  e_wdata;
  logic [EAW-1:0]   e_raddr;
  logic [2*NW-1:0]  e_rdata;
  logic             d_we;
  logic [NAW-1:0]   d_waddr;
  logic [DW-1:0]    d_wdata;
  logic [NAW-1:0]   d_raddr;
  logic [DW-1:0]    d_rdata;
  logic             q_we;
  logic [NAW-1:0]   q_waddr;
  logic [NW-1:0]    q_wdata;
  logic [NAW-1:0]   q_raddr;
  logic [NW-1:0]    q_rdata;

  logic [NW-1:0] esrc;
  logic [NW-1:0] edst;
  logic [CW-1:0] n_ext;
  logic          cmd_acc;
  logic          load_ok;
  logic          e_issue;
  logic          hit;
  logic [DW-1:0] cur;
  logic          push_scan;
  logic          push_seed;
  logic          emit_go;
  logic [CW-1:0] cfg_v;

  tsk_ram #(.W(2 * NW), .DEPTH(MAX_EDGES)) u_edge_mem (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  tsk_ram #(.W(DW), .DEPTH(MAX_NODES)) u_deg_mem (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata)
  );

  tsk_ram #(.W(NW), .DEPTH(MAX_NODES)) u_queue_mem (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  assign cfg_ready = 1'b1;
  assign cmd_ready = (state == S_IDLE);
  assign cmd_acc   = cmd_valid && cmd_ready;
  assign n_ext     = CW'(n_reg);
  assign esrc      = e_rdata[2*NW-1:NW];
  assign edst      = e_rdata[NW-1:0];

  // Clamp the written node count into range
  always_comb begin
    cfg_v = cfg_data;
    if (cfg_data == '0) begin
      cfg_v = CW'(1);
    end else if (cfg_data > CW'(MAX_NODES)) begin
      cfg_v = CW'(MAX_NODES);
    end
  end

  // Edge intake and edge-memory scan
  always_comb begin
    load_ok = cmd_acc && (cmd.func == tsk_pkg::FUNC_ADD)
              && ({1'b0, cmd.src_node} < n_ext) && ({1'b0, cmd.dst_node} < n_ext)
              && (total < ECW'(MAX_EDGES));
    e_we    = load_ok;
    e_waddr = total[EAW-1:0];
    e_wdata = {cmd.src_node, cmd.dst_node};
    e_raddr = e_cnt[EAW-1:0];
    e_issue = ((state == S_ADJ) || (state == S_SCAN)) && (e_cnt != total);
  end

  // Select in-degree reads and stage-two hits
  always_comb begin
    hit = 1'b0;
    if (state == S_ADJ) begin
      hit = p1_v && ({1'b0, esrc} >= n_ext);
    end else if (state == S_SCAN) begin
      hit = p1_v && (esrc == node) && ({1'b0, edst} < n_ext);
    end
    case (state)
      S_IDLE:  d_raddr = cmd.dst_node[NAW-1:0];
      S_SEED:  d_raddr = cnt[NAW-1:0];
      default: d_raddr = edst[NAW-1:0];
    endcase
  end

  // Read-modify-write of the in-degree with forwarding of the last write
  always_comb begin
    cur       = (fw_v && (fw_a == p2_d)) ? fw_d : d_rdata;
    push_scan = p2_v && p2_push && (cur == DW'(1));
    push_seed = sd_v && (d_rdata == '0);
    if (state == S_CLEAR) begin
      d_we    = 1'b1;
      d_waddr = cnt[NAW-1:0];
      d_wdata = '0;
    end else begin
      d_we    = p2_v && (p2_inc || (cur != '0));
      d_waddr = p2_d;
      d_wdata = p2_inc ? (cur + DW'(1)) : (cur - DW'(1));
    end
    q_we    = push_scan || push_seed;
    q_waddr = tail[NAW-1:0];
    q_wdata = push_seed ? NW'(sd_i) : NW'(p2_d);
    q_raddr = ((state == S_EMRD) || (state == S_EMLD)) ? cnt[NAW-1:0] : head[NAW-1:0];
    emit_go = !res_valid || res_ready;
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      n_reg     <= NCW'(1);
      total     <= '0;
      drop      <= 1'b0;
      head      <= '0;
      tail      <= '0;
      cnt       <= '0;
      e_cnt     <= '0;
      cyc       <= 1'b0;
      p1_v      <= 1'b0;
      p2_v      <= 1'b0;
      sd_v      <= 1'b0;
      fw_v      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        n_reg <= NCW'(cfg_v);
      end
      // forwarding register tracks the last in-degree write
      fw_v <= d_we && (state != S_CLEAR);
      fw_a <= d_waddr;
      fw_d <= d_wdata;
      // stages one and two of the edge pipeline
      p1_v    <= e_issue;
      if (e_issue) begin
        e_cnt <= e_cnt + ECW'(1);
      end
      p2_v    <= load_ok || hit;
      p2_inc  <= load_ok;
      p2_push <= (state == S_SCAN);
      p2_d    <= load_ok ? cmd.dst_node[NAW-1:0] : edst[NAW-1:0];
      sd_v    <= 1'b0;
      if (q_we) begin
        tail <= tail + NCW'(1);
      end
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          total <= '0;
          drop  <= 1'b0;
          head  <= '0;
          tail  <= '0;
          cnt   <= cnt + NCW'(1);
          if (cnt == NCW'(MAX_NODES - 1)) begin
            cnt   <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (load_ok) begin
            total <= total + ECW'(1);
          end else if (cmd_acc && (cmd.func == tsk_pkg::FUNC_ADD)) begin
            drop <= 1'b1;
          end
          if (cmd_acc && (cmd.func == tsk_pkg::FUNC_RUN)) begin
            e_cnt <= '0;
            state <= S_ADJ;
          end
        end
        S_ADJ: begin
          if (!e_issue && !p1_v && !p2_v) begin
            cnt   <= '0;
            state <= S_SEED;
          end
        end
        S_SEED: begin
          if (cnt != n_reg) begin
            sd_v <= 1'b1;
            sd_i <= cnt[NAW-1:0];
            cnt  <= cnt + NCW'(1);
          end else if (!sd_v) begin
            state <= S_POPRD;
          end
        end
        S_POPRD: begin
          if (head < tail) begin
            state <= S_POPWT;
          end else begin
            cyc   <= (head != n_reg);
            cnt   <= '0;
            state <= S_EMRD;
          end
        end
        S_POPWT: begin
          node  <= q_rdata;
          head  <= head + NCW'(1);
          e_cnt <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (!e_issue && !p1_v && !p2_v) begin
            state <= S_POPRD;
          end
        end
        S_EMRD: begin
          state <= S_EMLD;
        end
        S_EMLD: begin
          if (emit_go) begin
            res_valid         <= 1'b1;
            res.edges_dropped <= drop;
            res.cycle_found   <= cyc;
            if (cyc) begin
              res.node_out <= '0;
              res.last     <= 1'b1;
              cnt          <= '0;
              state        <= S_CLEAR;
            end else begin
              res.node_out <= q_rdata;
              res.last     <= (cnt == n_reg - NCW'(1));
              cnt          <= cnt + NCW'(1);
              state        <= S_EMRD;
              if (cnt == n_reg - NCW'(1)) begin
                cnt   <= '0;
                state <= S_CLEAR;
              end
            end
          end
        end
        default: begin
          state <= S_CLEAR;
          cnt   <= '0;
        end
      endcase
    end
  end

  `include "topological_sort_kahn_assert.svh"

  `TSK_CHECK(a_tail_bound, tail <= n_reg || state == S_IDLE, "queue tail passed node count")
  `TSK_CHECK(a_head_tail, head <= tail, "queue head passed tail")
  `TSK_IMPLY(a_push_room, q_we, tail < n_reg, "queue push with no room")
  `TSK_IMPLY(a_load_idle, e_we, state == S_IDLE && total < ECW'(MAX_EDGES), "edge store overrun")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Kahn sort engine: directed edge and run items
// from a table, then random graphs, scored against a local sort model and the table's expected results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int NODES = 64;
  localparam int EDGES = 1024;
  localparam int WATCHDOG = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tsk_pkg::CFG_W-1:0] cfg_data = '0;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  tsk_pkg::cmd_item_t cmd = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  tsk_pkg::res_item_t res;

  topological_sort_kahn #(.MAX_NODES(NODES), .MAX_EDGES(EDGES)) i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the graph state
  logic [5:0] edge_src [EDGES];
  logic [5:0] edge_dst [EDGES];
  int edge_count;
  int indeg [NODES];
  bit dropped;
  int node_limit = 1;

  tsk_pkg::res_item_t order_q[$];
  int errors = 0;
  int items_sent = 0;
  int runs_sent = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  bit stop_sink = 1'b0;

  typedef struct {
    bit is_cfg;
    int cfg_val;
    tsk_pkg::cmd_item_t c;
    bit has_exp;
    tsk_pkg::res_item_t want_res;
  } step_t;

  step_t steps[$];

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void clear_graph();
    edge_count = 0;
    dropped = 1'b0;
    for (int i = 0; i < NODES; i++) indeg[i] = 0;
  endfunction

  // Predict the outcome of one command item
  function automatic void sort_model(tsk_pkg::cmd_item_t c);
    int deg [NODES];
    int fifo [NODES];
    int head, tail, done, nd;
    tsk_pkg::res_item_t r;
    head = 0;
    tail = 0;
    done = 0;
    if (c.func == tsk_pkg::FUNC_ADD) begin
      if (c.src_node >= node_limit || c.dst_node >= node_limit || edge_count >= EDGES) begin
        dropped = 1'b1;
      end else begin
        edge_src[edge_count] = c.src_node;
        edge_dst[edge_count] = c.dst_node;
        edge_count++;
        indeg[c.dst_node]++;
      end
      return;
    end
    for (int i = 0; i < NODES; i++) deg[i] = indeg[i];
    for (int e = 0; e < edge_count; e++)
      if (edge_src[e] >= node_limit && deg[edge_dst[e]] > 0) deg[edge_dst[e]]--;
    for (int i = 0; i < node_limit; i++)
      if (deg[i] == 0) fifo[tail++] = i;
    while (head < tail) begin
      nd = fifo[head++];
      done++;
      for (int e = 0; e < edge_count; e++) begin
        if (edge_src[e] == nd && edge_dst[e] < node_limit && deg[edge_dst[e]] > 0) begin
          deg[edge_dst[e]]--;
          if (deg[edge_dst[e]] == 0 && tail < NODES) fifo[tail++] = edge_dst[e];
        end
      end
    end
    if (done != node_limit) begin
      r = '{node_out: '0, last: 1'b1, cycle_found: 1'b1, edges_dropped: dropped};
      order_q.insert(order_q.size(), r);
    end else begin
      for (int k = 0; k < done; k++) begin
        r.node_out = fifo[k][5:0];
        r.last = (k + 1 == done);
        r.cycle_found = 1'b0;
        r.edges_dropped = dropped;
        order_q.insert(order_q.size(), r);
      end
    end
    clear_graph();
  endfunction

  // Send one command item, predicting at acceptance; valid stays up for a
  // following item with no gap
  task automatic send_cmd(tsk_pkg::cmd_item_t c);
    int g;
    g = gap_len();
    if (g > 0) begin
      cmd_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    cmd <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!cmd_ready);
    sort_model(c);
    items_sent++;
    if (c.func == tsk_pkg::FUNC_RUN) runs_sent++;
    @(negedge clk);
  endtask

  // Wait for the engine to drain, then write node_count
  task automatic write_nodes(int v);
    int m;
    cmd_valid <= 1'b0;
    m = v & 127;
    while (order_q.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    cfg_data <= v[tsk_pkg::CFG_W-1:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    node_limit = (m == 0) ? 1 : (m > NODES) ? NODES : m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic tsk_pkg::cmd_item_t make_edge(int s, int d);
    tsk_pkg::cmd_item_t c;
    c.func = tsk_pkg::FUNC_ADD;
    c.src_node = s[5:0];
    c.dst_node = d[5:0];
    return c;
  endfunction

  function automatic tsk_pkg::cmd_item_t make_run();
    tsk_pkg::cmd_item_t c;
    c = '0;
    c.func = tsk_pkg::FUNC_RUN;
    c.src_node = 6'($urandom);
    c.dst_node = 6'($urandom);
    return c;
  endfunction

  // Single flagged result: node 0, last set
  function automatic tsk_pkg::res_item_t flag_res(bit cyc, bit drp);
    tsk_pkg::res_item_t r;
    r.node_out = '0;
    r.last = 1'b1;
    r.cycle_found = cyc;
    r.edges_dropped = drp;
    return r;
  endfunction

  function automatic void add_step(bit is_cfg, int cfg_val, tsk_pkg::cmd_item_t c,
                                   bit has_exp, tsk_pkg::res_item_t want_res);
    step_t s;
    s.is_cfg = is_cfg;
    s.cfg_val = cfg_val;
    s.c = c;
    s.has_exp = has_exp;
    s.want_res = want_res;
    steps.insert(steps.size(), s);
  endfunction

  // Random graph of size n; ordered edges are acyclic unless cyc is set, stray random edges may add cycles
  task automatic random_graph(int n, bit cyc);
    int ne, s, d;
    int perm [NODES];
    for (int i = 0; i < n; i++) perm[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      s = $urandom_range(0, i);
      d = perm[i]; perm[i] = perm[s]; perm[s] = d;
    end
    ne = $urandom_range(0, 2 * n);
    for (int i = 0; i < ne; i++) begin
      s = $urandom_range(0, n - 1);
      d = $urandom_range(0, n - 1);
      if (s > d) begin int t; t = s; s = d; d = t; end
      if (s == d && !cyc) continue;
      if ($urandom_range(0, 19) == 0) send_cmd(make_edge($urandom_range(0, 63), $urandom_range(0, 63)));
      else send_cmd(make_edge(perm[s], perm[d]));
    end
    if (cyc && n > 1) begin
      send_cmd(make_edge(perm[0], perm[1]));
      send_cmd(make_edge(perm[1], perm[0]));
    end
    send_cmd(make_run());
  endtask

  // Result sink with random stalls; compare against the oldest prediction
  initial begin
    tsk_pkg::res_item_t want;
    @(negedge clk);
    while (!stop_sink) begin
      if ($urandom_range(0, 49) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(5, 30)) @(negedge clk);
      end
      res_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 9) == 0);
      @(posedge clk);
      if (res_valid && res_ready) begin
        results_seen++;
        if (order_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", res);
        end else begin
          want = order_q.pop_front();
          if (res !== want) begin
            errors++;
            if (errors <= 10) $display("result %0d: expected %p, got %p", results_seen, want, res);
          end
        end
      end
      @(negedge clk);
    end
  end

  // Watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if ((cmd_valid && cmd_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("topological_sort_kahn: mismatch");
      $finish;
    end
  end

  initial begin
    clear_graph();
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Directed table: single node run, out-of-range edge, small graphs,
    // duplicates, cycle, node count clamp and shrink
    add_step(0, 0, make_run(), 1, flag_res(1'b0, 1'b0));
    add_step(0, 0, make_edge(63, 63), 0, '0);
    add_step(0, 0, make_run(), 1, flag_res(1'b0, 1'b1));
    add_step(1, 0, '0, 0, '0);
    add_step(1, 4, '0, 0, '0);
    add_step(0, 0, make_run(), 0, '0);
    add_step(0, 0, make_edge(3, 1), 0, '0);
    add_step(0, 0, make_edge(3, 1), 0, '0);
    add_step(0, 0, make_edge(1, 0), 0, '0);
    add_step(0, 0, make_edge(2, 0), 0, '0);
    add_step(0, 0, make_run(), 0, '0);
    add_step(0, 0, make_edge(0, 1), 0, '0);
    add_step(0, 0, make_edge(1, 0), 0, '0);
    add_step(0, 0, make_run(), 1, flag_res(1'b1, 1'b0));
    add_step(0, 0, make_edge(2, 2), 0, '0);
    add_step(0, 0, make_edge(3, 0), 0, '0);
    add_step(1, 2, '0, 0, '0);
    add_step(0, 0, make_run(), 0, '0);
    add_step(1, 127, '0, 0, '0);
    add_step(0, 0, make_edge(63, 0), 0, '0);
    add_step(0, 0, make_edge(0, 63), 0, '0);
    add_step(0, 0, make_run(), 1, flag_res(1'b1, 1'b0));
    foreach (steps[i]) begin
      if (steps[i].is_cfg) write_nodes(steps[i].cfg_val);
      else begin
        send_cmd(steps[i].c);
        if (steps[i].has_exp) order_q[order_q.size() - 1] = steps[i].want_res;
      end
    end

    // Random graphs over several sizes
    while (items_sent < 440) begin
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 64) : $urandom_range(1, 12);
      if ($urandom_range(0, 3) == 0) write_nodes(n);
      random_graph(node_limit, $urandom_range(0, 4) == 0);
    end
    cmd_valid <= 1'b0;

    while (order_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    stop_sink = 1'b1;
    $display("covered %0d items, %0d sort runs, %0d order results", items_sent, runs_sent,
             results_seen);
    if (errors == 0) $display("topological_sort_kahn: match");
    else $display("topological_sort_kahn: mismatch");
    $finish;
  end
endmodule
